FILE: hw/rtl/mtpc_pkg.sv
// shared types, constants and functions of the memory test pattern checker
package mtpc_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StrideW = 13;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_KIND   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_ADDRESS   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_ADDRESS    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ADDRESS_STRIDE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_SEED   = 3'd4;

  // register reset values
  localparam logic [KindW-1:0]   RST_PATTERN_KIND   = 2'd0;
  localparam logic [AddrW-1:0]   RST_BASE_ADDRESS   = 32'h8000_0000;
  localparam logic [AddrW-1:0]   RST_END_ADDRESS    = 32'h80FF_F000;
  localparam logic [StrideW-1:0] RST_ADDRESS_STRIDE = 13'd4;
  localparam logic [WordW-1:0]   RST_PATTERN_SEED   = 32'hCAFE_BABE;

  // stride used in place of zero
  localparam logic [StrideW-1:0] DEFAULT_STRIDE = 13'd4;

  // pattern kinds
  localparam logic [KindW-1:0] KIND_ADDR     = 2'd0;
  localparam logic [KindW-1:0] KIND_INV_ADDR = 2'd1;
  localparam logic [KindW-1:0] KIND_XORSHIFT = 2'd2;

  // command codes
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_RUNNING = 2'd0;
  localparam logic [1:0] STATUS_PASSED  = 2'd1;
  localparam logic [1:0] STATUS_FAILED  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WRITE  = 3'd1,
    PH_VERIFY = 3'd2,
    PH_PASSED = 3'd3,
    PH_FAILED = 3'd4
  } phase_t;

  typedef struct packed {
    logic [KindW-1:0]   pattern_kind;
    logic [AddrW-1:0]   base_address;
    logic [AddrW-1:0]   end_address;
    logic [StrideW-1:0] address_stride;
    logic [WordW-1:0]   pattern_seed;
  } cfg_t;

  typedef struct packed {
    logic [AddrW-1:0] access_address;
    logic             is_write;
    logic [WordW-1:0] pattern_word;
    logic             mismatch;
    logic [1:0]       test_status;
    logic             last;
  } result_t;

  // xorshift32 with shifts 13, 17, 5
  function automatic logic [WordW-1:0] xorshift_step(input logic [WordW-1:0] v);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

FILE: hw/rtl/mtpc_cfg.sv
// configuration register file of the memory test pattern checker
module mtpc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [mtpc_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [mtpc_pkg::CfgDataW-1:0] wr_data,
  output mtpc_pkg::cfg_t                cfg
);
  import mtpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_PATTERN_KIND:   cfg_nxt.pattern_kind   = wr_data[KindW-1:0];
        CFG_BASE_ADDRESS:   cfg_nxt.base_address   = wr_data[AddrW-1:0];
        CFG_END_ADDRESS:    cfg_nxt.end_address    = wr_data[AddrW-1:0];
        CFG_ADDRESS_STRIDE: cfg_nxt.address_stride = wr_data[StrideW-1:0];
        CFG_PATTERN_SEED:   cfg_nxt.pattern_seed   = wr_data[WordW-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_kind   <= RST_PATTERN_KIND;
      cfg_r.base_address   <= RST_BASE_ADDRESS;
      cfg_r.end_address    <= RST_END_ADDRESS;
      cfg_r.address_stride <= RST_ADDRESS_STRIDE;
      cfg_r.pattern_seed   <= RST_PATTERN_SEED;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/mtpc_seq.sv
// test sequencer: phase, address and generator state, result computation
module mtpc_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic                        command,
  input  logic [mtpc_pkg::WordW-1:0]  read_word,
  input  mtpc_pkg::cfg_t              cfg,
  output logic                        res_valid,
  output mtpc_pkg::result_t           res
);
  import mtpc_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [AddrW-1:0] addr_r, addr_nxt;
  logic [WordW-1:0] gen_r, gen_nxt;

  logic [StrideW-1:0] stride;
  logic [AddrW:0]     sum;
  logic               pass_end;
  logic               empty;
  logic [WordW-1:0]   gen_step;
  logic [WordW-1:0]   pat;
  logic               differ;

  // shared datapath
  always_comb begin
    stride   = (cfg.address_stride == '0) ? DEFAULT_STRIDE : cfg.address_stride;
    sum      = {1'b0, addr_r} + {{(AddrW+1-StrideW){1'b0}}, stride};
    pass_end = (sum >= {1'b0, cfg.end_address});
    empty    = (cfg.base_address >= cfg.end_address);
    gen_step = xorshift_step(gen_r);
    unique case (cfg.pattern_kind)
      KIND_INV_ADDR: pat = ~addr_r;
      KIND_XORSHIFT: pat = gen_step;
      default:       pat = addr_r;
    endcase
    differ = (read_word != pat);
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    gen_nxt   = gen_r;
    if (take) begin
      if (command == CMD_START) begin
        addr_nxt  = cfg.base_address;
        gen_nxt   = cfg.pattern_seed;
        phase_nxt = empty ? PH_PASSED : PH_WRITE;
      end else begin
        unique case (phase_r)
          PH_WRITE: begin
            gen_nxt  = (cfg.pattern_kind == KIND_XORSHIFT) ? gen_step : gen_r;
            addr_nxt = sum[AddrW-1:0];
            if (pass_end) begin
              phase_nxt = PH_VERIFY;
              addr_nxt  = cfg.base_address;
              gen_nxt   = cfg.pattern_seed;
            end
          end
          PH_VERIFY: begin
            gen_nxt = (cfg.pattern_kind == KIND_XORSHIFT) ? gen_step : gen_r;
            if (differ) begin
              phase_nxt = PH_FAILED;
            end else begin
              addr_nxt = sum[AddrW-1:0];
              if (pass_end) phase_nxt = PH_PASSED;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // result of the beat being taken
  always_comb begin
    res_valid          = 1'b0;
    res.access_address = addr_r;
    res.is_write       = 1'b0;
    res.pattern_word   = pat;
    res.mismatch       = 1'b0;
    res.test_status    = STATUS_RUNNING;
    res.last           = 1'b0;
    if (take) begin
      if (command == CMD_START) begin
        res_valid          = empty;
        res.access_address = cfg.base_address;
        res.pattern_word   = '0;
        res.test_status    = STATUS_PASSED;
        res.last           = 1'b1;
      end else begin
        unique case (phase_r)
          PH_WRITE: begin
            res_valid    = 1'b1;
            res.is_write = 1'b1;
          end
          PH_VERIFY: begin
            res_valid = 1'b1;
            if (differ) begin
              res.mismatch    = 1'b1;
              res.test_status = STATUS_FAILED;
              res.last        = 1'b1;
            end else if (pass_end) begin
              res.test_status = STATUS_PASSED;
              res.last        = 1'b1;
            end
          end
          default: res_valid = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      gen_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      gen_r   <= gen_nxt;
    end
  end

endmodule

FILE: hw/rtl/mtpc_outreg.sv
// output register stage with valid/ready flow control
module mtpc_outreg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                res_valid,
  input  mtpc_pkg::result_t   res,
  output logic                out_valid,
  input  logic                out_ready,
  output mtpc_pkg::result_t   out_res
);
  import mtpc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;
  logic    take;

  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take)           valid_nxt = res_valid;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) res_r <= res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: hw/rtl/memory_test_pattern_checker.sv
// top level of the memory test pattern checker
//
// usage:
//   cfg channel: cfg_index selects the register (0 pattern kind, 1 base
//   address, 2 end address, 3 stride, 4 seed), cfg_wdata the value; always
//   ready; user must write only while idle, the block does not enforce it
//   in channel: one beat per command, in_command 0 starts a test, 1 advances
//   one access; in_read_word is the word read back during the verify pass
//   out channel: at most one result beat per input beat with the access
//   address, write flag, pattern word, mismatch, status and last flag
// the registered result of a taken beat is on out_valid in the next cycle
// throughput: one input beat per cycle unless the receiver stalls; sequencer
//   state and the result register both update in the cycle a beat is taken
// a start with a non-empty range and an advance while not running give no
//   result beat
// reset: synchronous active low; registers return to their reset values,
//   the sequencer goes idle and the output register empties
// when the receiver stalls the result is held and in_ready drops until it is
//   taken; a new beat is accepted in the same cycle the held one leaves
module memory_test_pattern_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mtpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mtpc_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [mtpc_pkg::WordW-1:0]    in_read_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mtpc_pkg::AddrW-1:0]    out_access_address,
  output logic                          out_is_write,
  output logic [mtpc_pkg::WordW-1:0]    out_pattern_word,
  output logic                          out_mismatch,
  output logic [1:0]                    out_test_status,
  output logic                          out_last
);
  import mtpc_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    take;

  // register writes never stall
  assign cfg_ready = 1'b1;

  mtpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // the sequencer state moves only on an accepted beat
  assign take = in_valid && in_ready;

  mtpc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .command   (in_command),
    .read_word (in_read_word),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register parts the two channels
  mtpc_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_access_address = out_res.access_address;
  assign out_is_write       = out_res.is_write;
  assign out_pattern_word   = out_res.pattern_word;
  assign out_mismatch       = out_res.mismatch;
  assign out_test_status    = out_res.test_status;
  assign out_last           = out_res.last;

endmodule

FILE: dv/memory_test_pattern_checker_tb.sv
// self-checking testbench for the memory test pattern checker: queued stimulus, shadow sequencer
`timescale 1ns / 1ps

module memory_test_pattern_checker_tb;
  import mtpc_pkg::*;

  // cycles without any accepted beat before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // length of the deliberate receiver hold-off
  localparam int unsigned LONG_HOLD      = 300;
  // quiet cycles after the last awaited result, covers starts that give no beat
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned MAX_LOGGED     = 60;

  // how the driver fills the read word when it offers a beat
  typedef enum logic [1:0] {
    WORD_RANDOM,
    WORD_MATCH,
    WORD_FLIP
  } word_src_t;

  typedef struct {
    logic             cmd;
    logic [WordW-1:0] word;
    word_src_t        src;
  } stim_beat_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index    = '0;
  logic [CfgDataW-1:0] cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                in_command   = CMD_START;
  logic [WordW-1:0]    in_read_word = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [AddrW-1:0]    out_access_address;
  logic                out_is_write;
  logic [WordW-1:0]    out_pattern_word;
  logic                out_mismatch;
  logic [1:0]          out_test_status;
  logic                out_last;

  // shadow of the register file and of the sequencer state
  cfg_t             live_cfg = {RST_PATTERN_KIND, RST_BASE_ADDRESS, RST_END_ADDRESS,
                                RST_ADDRESS_STRIDE, RST_PATTERN_SEED};
  phase_t           seq_phase = PH_IDLE;
  logic [AddrW-1:0] seq_addr  = '0;
  logic [WordW-1:0] seq_gen   = '0;

  stim_beat_t stim_q[$];
  result_t    awaited_results[$];

  int unsigned beats_queued   = 0;
  int unsigned beats_accepted = 0;
  int unsigned error_count    = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  logic        hold_kick      = 1'b0;

  memory_test_pattern_checker dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_read_word      (in_read_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_access_address(out_access_address),
    .out_is_write      (out_is_write),
    .out_pattern_word  (out_pattern_word),
    .out_mismatch      (out_mismatch),
    .out_test_status   (out_test_status),
    .out_last          (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_error(input string what);
    if (error_count < MAX_LOGGED) $display("%0t mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // xorshift32, shifts 13 / 17 / 5
  function automatic logic [WordW-1:0] xorshift32(input logic [WordW-1:0] s);
    logic [WordW-1:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    return t ^ (t << 5);
  endfunction

  // word the sequencer produces at addr from generator state gen, no side effects
  function automatic logic [WordW-1:0] expected_word(input logic [AddrW-1:0] addr,
                                                     input logic [WordW-1:0] gen);
    case (live_cfg.pattern_kind)
      KIND_INV_ADDR: return ~addr;
      KIND_XORSHIFT: return xorshift32(gen);
      default:       return addr;  // unused kind falls back to address-in-data
    endcase
  endfunction

  // advance the shadow sequencer by one accepted command, queue the beat it gives
  task automatic step_sequencer(input logic cmd, input logic [WordW-1:0] rd);
    result_t            r;
    logic [WordW-1:0]   pat;
    logic [AddrW:0]     nxt;
    logic [StrideW-1:0] step;
    step = (live_cfg.address_stride == '0) ? DEFAULT_STRIDE : live_cfg.address_stride;
    r = '0;
    if (cmd == CMD_START) begin
      seq_addr = live_cfg.base_address;
      seq_gen  = live_cfg.pattern_seed;
      if (live_cfg.base_address >= live_cfg.end_address) begin
        // empty region passes on the spot with a single closing beat
        seq_phase        = PH_PASSED;
        r.access_address = live_cfg.base_address;
        r.test_status    = STATUS_PASSED;
        r.last           = 1'b1;
        awaited_results.push_back(r);
      end else begin
        seq_phase = PH_WRITE;
      end
    end else if (seq_phase == PH_WRITE || seq_phase == PH_VERIFY) begin
      pat = expected_word(seq_addr, seq_gen);
      if (live_cfg.pattern_kind == KIND_XORSHIFT) seq_gen = pat;
      r.access_address = seq_addr;
      r.pattern_word   = pat;
      // 33-bit sum so a carry out of the address space ends the pass
      nxt = {1'b0, seq_addr} + 33'(step);
      if (seq_phase == PH_WRITE) begin
        r.is_write = 1'b1;
        seq_addr   = nxt[AddrW-1:0];
        if (nxt >= {1'b0, live_cfg.end_address}) begin
          seq_phase = PH_VERIFY;
          seq_addr  = live_cfg.base_address;
          seq_gen   = live_cfg.pattern_seed;
        end
      end else if (rd !== pat) begin
        seq_phase     = PH_FAILED;
        r.mismatch    = 1'b1;
        r.test_status = STATUS_FAILED;
        r.last        = 1'b1;
      end else begin
        seq_addr = nxt[AddrW-1:0];
        if (nxt >= {1'b0, live_cfg.end_address}) begin
          seq_phase     = PH_PASSED;
          r.test_status = STATUS_PASSED;
          r.last        = 1'b1;
        end
      end
      awaited_results.push_back(r);
    end
    // advances while idle, passed or failed are dropped without a beat
  endtask

  // input driver: one beat in flight, refilled from stim_q at the edge it is taken
  always @(posedge clk) begin : drive_in
    stim_beat_t       nxt;
    logic [WordW-1:0] want;
    logic             taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        step_sequencer(in_command, in_read_word);
        beats_accepted++;
      end
      if (!in_valid || taken) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = stim_q.pop_front();
          // shadow state is current here, so a matching read word can be built
          want = expected_word(seq_addr, seq_gen);
          case (nxt.src)
            WORD_MATCH: in_read_word <= want;
            WORD_FLIP:  in_read_word <= want ^ ((nxt.word == '0) ? 32'h1 : nxt.word);
            default:    in_read_word <= nxt.word;
          endcase
          in_command <= nxt.cmd;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin : watch_out
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          flag_error($sformatf("result beat with nothing awaited, address %h",
                               out_access_address));
        end else begin
          want = awaited_results.pop_front();
          check_field("access_address", out_access_address, want.access_address);
          check_field("is_write", 32'(out_is_write), 32'(want.is_write));
          check_field("pattern_word", out_pattern_word, want.pattern_word);
          check_field("mismatch", 32'(out_mismatch), 32'(want.mismatch));
          check_field("test_status", 32'(out_test_status), 32'(want.test_status));
          check_field("last", 32'(out_last), 32'(want.last));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, counted here so the sender keeps offering meanwhile
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog on cycles where no channel moves a beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("[memory_test_pattern_checker] ERROR");
        $finish;
      end
    end
  end

  // register write, shadow updated once the beat is taken
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PATTERN_KIND:   live_cfg.pattern_kind   = data[KindW-1:0];
      CFG_BASE_ADDRESS:   live_cfg.base_address   = data;
      CFG_END_ADDRESS:    live_cfg.end_address    = data;
      CFG_ADDRESS_STRIDE: live_cfg.address_stride = data[StrideW-1:0];
      CFG_PATTERN_SEED:   live_cfg.pattern_seed   = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic push_beat(input logic cmd, input word_src_t src, input logic [WordW-1:0] word);
    stim_beat_t b;
    b.cmd  = cmd;
    b.src  = src;
    b.word = word;
    stim_q.push_back(b);
    beats_queued++;
  endtask

  // wait until every queued beat is in and every awaited result is out
  task automatic settle();
    do @(posedge clk); while (beats_accepted != beats_queued || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  function automatic int count_words(input logic [AddrW-1:0] base,
                                     input logic [AddrW-1:0] limit,
                                     input logic [StrideW-1:0] step);
    logic [AddrW:0] a;
    int n;
    a = {1'b0, base};
    n = 0;
    while (a < {1'b0, limit} && n < 100000) begin
      a += 33'(step);
      n++;
    end
    return n;
  endfunction

  // random small region, all five registers rewritten; returns its word count
  task automatic configure_region(output int words);
    logic [StrideW-1:0] stride;
    logic [StrideW-1:0] step;
    logic [AddrW-1:0]   base;
    logic [AddrW-1:0]   limit;
    logic [AddrW:0]     span_end;
    int                 want;
    logic [WordW-1:0]   seed;
    case ($urandom_range(5))
      0: stride = 13'd4;
      1: stride = 13'd64;
      2: stride = 13'd4096;
      3: stride = '0;
      4: stride = 13'h1FFF;
      default: stride = 13'($urandom_range(8191, 1));
    endcase
    step = (stride == '0) ? DEFAULT_STRIDE : stride;
    case ($urandom_range(9))
      0: base = '0;
      1: base = 32'hFFFF_FFFF - $urandom_range(3 * step, 0);  // top of the address space
      default: base = $urandom;
    endcase
    want = $urandom_range(10, 1);
    if ($urandom_range(11) == 0) begin
      limit = $urandom_range(base, 0);  // empty region
    end else begin
      span_end = {1'b0, base} +
                 33'((want - 1) * step + 1 + $urandom_range(step - 1, 0));
      limit = span_end[AddrW] ? 32'hFFFF_FFFF : span_end[AddrW-1:0];
    end
    case ($urandom_range(3))
      0: seed = '0;
      1: seed = 32'hFFFF_FFFF;
      default: seed = $urandom;
    endcase
    words = count_words(base, limit, step);
    write_reg(CFG_PATTERN_KIND, ($urandom_range(7) == 0) ? $urandom : $urandom_range(3, 0));
    write_reg(CFG_BASE_ADDRESS, base);
    write_reg(CFG_END_ADDRESS, limit);
    // upper bits of the stride word are sometimes junk, only the low field counts
    write_reg(CFG_ADDRESS_STRIDE, ($urandom_range(3) == 0) ?
              (($urandom & 32'hFFFF_E000) | 32'(stride)) : 32'(stride));
    write_reg(CFG_PATTERN_SEED, seed);
  endtask

  // one test run: start, write pass, verify pass; some runs cut short or corrupted
  task automatic queue_run(input int words);
    int style;
    int cut;
    style = $urandom_range(99);
    cut   = (words == 0) ? 0 : $urandom_range(2 * words - 1, 0);
    push_beat(CMD_START, WORD_RANDOM, $urandom);
    for (int i = 0; i < 2 * words; i++) begin
      if (style < 10 && i == cut) return;  // aborted, next start restarts
      if (i < words || style < 18) begin
        push_beat(CMD_ADVANCE, WORD_RANDOM, $urandom);
      end else if ($urandom_range(99) < 4) begin
        push_beat(CMD_ADVANCE, WORD_FLIP, $urandom);
        break;
      end else begin
        push_beat(CMD_ADVANCE, WORD_MATCH, $urandom);
      end
    end
    // stray advance after the run has closed
    if ($urandom_range(2) == 0) push_beat(CMD_ADVANCE, WORD_RANDOM, $urandom);
  endtask

  initial begin : run_test
    int          words;
    int unsigned target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: advance while idle is dropped, then two writes of a long region
    push_beat(CMD_ADVANCE, WORD_RANDOM, 32'hFFFF_FFFF);
    push_beat(CMD_START, WORD_RANDOM, 32'h0);
    push_beat(CMD_ADVANCE, WORD_RANDOM, 32'h0);
    push_beat(CMD_ADVANCE, WORD_RANDOM, 32'hA5A5_5A5A);
    settle();

    // xorshift with an all-ones seed, clean pass, then a dropped advance
    write_reg(CFG_PATTERN_KIND, 32'(KIND_XORSHIFT));
    write_reg(CFG_BASE_ADDRESS, 32'h0000_1000);
    write_reg(CFG_END_ADDRESS, 32'h0000_100C);
    write_reg(CFG_ADDRESS_STRIDE, 32'd4);
    write_reg(CFG_PATTERN_SEED, 32'hFFFF_FFFF);
    push_beat(CMD_START, WORD_RANDOM, $urandom);
    repeat (3) push_beat(CMD_ADVANCE, WORD_RANDOM, $urandom);
    repeat (3) push_beat(CMD_ADVANCE, WORD_MATCH, $urandom);
    push_beat(CMD_ADVANCE, WORD_RANDOM, $urandom);
    settle();

    // inverted address with zero stride, bad read on the second verify word
    write_reg(CFG_PATTERN_KIND, 32'(KIND_INV_ADDR));
    write_reg(CFG_BASE_ADDRESS, 32'h0000_2000);
    write_reg(CFG_END_ADDRESS, 32'h0000_200C);
    write_reg(CFG_ADDRESS_STRIDE, 32'd0);
    push_beat(CMD_START, WORD_RANDOM, $urandom);
    repeat (3) push_beat(CMD_ADVANCE, WORD_RANDOM, $urandom);
    push_beat(CMD_ADVANCE, WORD_MATCH, $urandom);
    push_beat(CMD_ADVANCE, WORD_FLIP, 32'h0000_0100);
    push_beat(CMD_ADVANCE, WORD_RANDOM, $urandom);
    settle();

    // empty regions: base above end, then base equal to end
    write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFF0);
    write_reg(CFG_END_ADDRESS, 32'h0000_0010);
    push_beat(CMD_START, WORD_RANDOM, $urandom);
    settle();
    write_reg(CFG_END_ADDRESS, 32'hFFFF_FFF0);
    push_beat(CMD_START, WORD_RANDOM, $urandom);
    settle();

    // unused kind, junk upper bits, stride carrying out of the address space
    write_reg(CFG_PATTERN_KIND, 32'hFFFF_FFFF);
    write_reg(CFG_ADDRESS_STRIDE, 32'hFFFF_E008);
    write_reg(CFG_END_ADDRESS, 32'hFFFF_FFFF);
    push_beat(CMD_START, WORD_RANDOM, $urandom);
    repeat (2) push_beat(CMD_ADVANCE, WORD_RANDOM, $urandom);
    repeat (2) push_beat(CMD_ADVANCE, WORD_MATCH, $urandom);
    settle();

    // random regions, idling mode rotates every four regions
    for (int p = 0; p < 16; p++) begin
      set_idling(p % 4);
      for (int g = 0; g < 4; g++) begin
        settle();
        configure_region(words);
        target = beats_queued + 18;
        while (beats_queued < target) queue_run(words);
        if (p == 0 && g == 1) begin
          // receiver goes away while the sender streams, output fills and in_ready drops
          @(posedge clk);
          hold_kick <= 1'b1;
          @(posedge clk);
          hold_kick <= 1'b0;
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("[memory_test_pattern_checker] OK");
    end else begin
      $display("[memory_test_pattern_checker] ERROR");
    end
    $finish;
  end

endmodule
